// ----- rtl/sctu_pkg.sv -----
// Shared types and constants for the stopwatch / countdown timer unit.
`default_nettype none
package sctu_pkg;

   localparam int unsigned LIMIT_W    = 14;
   localparam int unsigned TICK_W     = 4;
   localparam int unsigned SECONDS_W  = 14;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 14;

   // Register map
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_UP_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTING_LIMIT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_SECOND = 2'd2;

   // Register reset values
   localparam logic [LIMIT_W-1:0] RST_COUNT_UP_LIMIT   = 14'd9999;
   localparam logic [LIMIT_W-1:0] RST_SETTING_LIMIT    = 14'd5999;
   localparam logic [TICK_W-1:0]  RST_TICKS_PER_SECOND = 4'd2;

   typedef struct packed {
      logic [LIMIT_W-1:0] count_up_limit;
      logic [LIMIT_W-1:0] setting_limit;
      logic [TICK_W-1:0]  ticks_per_second;
   } cfg_type;

   typedef struct packed {
      logic start_stop;
      logic mode;
      logic clear;
      logic up;
      logic down;
   } btn_type;

   typedef struct packed {
      logic              countdown;
      logic              running;
      logic              alarm;
      logic [TICK_W-1:0] tick_count;
      btn_type           history;
   } flags_type;

endpackage
`default_nettype wire

// ----- rtl/sctu_csr.sv -----
// Configuration register file for the stopwatch / countdown timer unit.
`default_nettype none
module sctu_csr
   import sctu_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire logic [CSR_IDX_W-1:0]  wr_index,
   input  wire logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_COUNT_UP_LIMIT:   cfg_in.count_up_limit   = wr_data[LIMIT_W-1:0];
            CSR_SETTING_LIMIT:    cfg_in.setting_limit    = wr_data[LIMIT_W-1:0];
            CSR_TICKS_PER_SECOND: cfg_in.ticks_per_second = wr_data[TICK_W-1:0];
            default:              cfg_in = cfg_ff;  // unmapped index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.count_up_limit   <= RST_COUNT_UP_LIMIT;
         cfg_ff.setting_limit    <= RST_SETTING_LIMIT;
         cfg_ff.ticks_per_second <= RST_TICKS_PER_SECOND;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ----- rtl/sctu_step.sv -----
// Next-state logic for one sample: button edges, setting, tick counting.
`default_nettype none
module sctu_step
   import sctu_pkg::*;
#(
   parameter int unsigned TIME_BITS = 14
) (
   input  wire logic [TIME_BITS-1:0] sec_cur,
   input  wire flags_type            flags_cur,
   input  wire btn_type              btn_now,
   input  wire logic                 tick,
   input  wire cfg_type              cfg,
   output logic      [TIME_BITS-1:0] sec_nxt,
   output flags_type                 flags_nxt
);

   localparam int unsigned CMP_W = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;

   btn_type             edge_det;
   logic [TIME_BITS-1:0] sec_a;
   logic [TIME_BITS-1:0] sec_b;
   logic [TIME_BITS-1:0] sec_c;
   logic                 sec_at_max;
   logic [TICK_W-1:0]    tc_inc;
   logic                 mode_v;
   logic                 run_v;
   logic                 alarm_v;

   assign edge_det = btn_now & ~flags_cur.history;

   always_comb begin
      mode_v  = flags_cur.countdown ^ edge_det.mode;
      run_v   = edge_det.mode ? 1'b0 : flags_cur.running;
      alarm_v = flags_cur.alarm;
      sec_a   = sec_cur;

      if (edge_det.start_stop) begin
         run_v = ~run_v;
         if (run_v) begin
            alarm_v = 1'b0;
         end
      end
      if (edge_det.clear) begin
         sec_a   = '0;
         alarm_v = 1'b0;
      end

      // manual setting, timer mode while stopped
      sec_b = sec_a;
      if (mode_v && !run_v && edge_det.up && (sec_a != {TIME_BITS{1'b1}})
          && (CMP_W'(sec_a) < CMP_W'(cfg.setting_limit))) begin
         sec_b = sec_a + 1'b1;
      end
      sec_c = sec_b;
      if (mode_v && !run_v && edge_det.down && (sec_b != '0)) begin
         sec_c = sec_b - 1'b1;
      end

      // tick prescaler and second count
      sec_at_max = (sec_c == {TIME_BITS{1'b1}});
      tc_inc     = flags_cur.tick_count + 1'b1;
      sec_nxt    = sec_c;
      flags_nxt.tick_count = flags_cur.tick_count;
      if (tick && run_v) begin
         if (tc_inc >= cfg.ticks_per_second) begin
            flags_nxt.tick_count = '0;
            if (!mode_v) begin
               if (!sec_at_max && (CMP_W'(sec_c) < CMP_W'(cfg.count_up_limit))) begin
                  sec_nxt = sec_c + 1'b1;
               end
            end else if (sec_c != '0) begin
               sec_nxt = sec_c - 1'b1;
               if (sec_c == TIME_BITS'(1)) begin
                  alarm_v = 1'b1;
               end
            end
         end else begin
            flags_nxt.tick_count = tc_inc;
         end
      end

      flags_nxt.countdown = mode_v;
      flags_nxt.running   = run_v;
      flags_nxt.alarm     = alarm_v;
      flags_nxt.history   = btn_now;
   end

endmodule
`default_nettype wire

// ----- rtl/stopwatch_countdown_timer_unit.sv -----
// Top level of the stopwatch / countdown timer unit.
//
//   channel  dir  handshake            contents
//   req_*    in   req_valid/req_stall  tick flag and five button levels, one sample
//   rsp_*    out  rsp_valid/rsp_stall  seconds, mode, running, alarm after the sample
//   csr_*    in   csr_valid/csr_ready  register index and write data
//
// A request is captured in an input register and is then applied to the timer
// state once the response slot is free; the state register itself is the result
// register, so the response is registered.
// One request per clock is sustained while rsp_stall is low; the only limit is
// the update of the state from the input register.
// Synchronous reset clears the state, the registers to their defaults, and
// both valid flags. A stalled response holds the state; the input register
// still takes one more request, then req_stall rises until rsp_stall drops.
// csr_ready is always high.
`default_nettype none
module stopwatch_countdown_timer_unit
   import sctu_pkg::*;
#(
   parameter int unsigned TIME_BITS = 14
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_tick,
   input  wire logic                  req_start_stop_pressed,
   input  wire logic                  req_mode_pressed,
   input  wire logic                  req_clear_pressed,
   input  wire logic                  req_up_pressed,
   input  wire logic                  req_down_pressed,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [SECONDS_W-1:0]       rsp_seconds_value,
   output logic                       rsp_countdown_mode,
   output logic                       rsp_is_running,
   output logic                       rsp_alarm_on,
   // register write port
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned OUT_W = (TIME_BITS > SECONDS_W) ? TIME_BITS : SECONDS_W;

   cfg_type              cfg;
   logic                 in_vld_ff;
   logic                 in_vld_in;
   logic                 in_tick_ff;
   btn_type              in_btn_ff;
   btn_type              req_btn;
   logic                 out_vld_ff;
   logic                 out_vld_in;
   logic [TIME_BITS-1:0] sec_ff;
   logic [TIME_BITS-1:0] sec_in;
   flags_type            flags_ff;
   flags_type            flags_in;
   logic                 req_take;
   logic                 advance;
   logic [OUT_W-1:0]     sec_wide;

   assign csr_ready = 1'b1;

   sctu_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // Handshake: the sample moves into the state when the result slot frees up
   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_vld_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
   assign out_vld_in = advance ? 1'b1 : (rsp_stall ? out_vld_ff : 1'b0);

   assign req_btn.start_stop = req_start_stop_pressed;
   assign req_btn.mode       = req_mode_pressed;
   assign req_btn.clear      = req_clear_pressed;
   assign req_btn.up         = req_up_pressed;
   assign req_btn.down       = req_down_pressed;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // input payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_tick_ff <= req_tick;
         in_btn_ff  <= req_btn;
      end
   end

   sctu_step #(
      .TIME_BITS (TIME_BITS)
   ) u_step (
      .sec_cur   (sec_ff),
      .flags_cur (flags_ff),
      .btn_now   (in_btn_ff),
      .tick      (in_tick_ff),
      .cfg       (cfg),
      .sec_nxt   (sec_in),
      .flags_nxt (flags_in)
   );

   // Timer state doubles as the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff   <= '0;
         flags_ff <= '0;
      end else if (advance) begin
         sec_ff   <= sec_in;
         flags_ff <= flags_in;
      end
   end

   assign sec_wide           = OUT_W'(sec_ff);
   assign rsp_valid          = out_vld_ff;
   assign rsp_seconds_value  = sec_wide[SECONDS_W-1:0];
   assign rsp_countdown_mode = flags_ff.countdown;
   assign rsp_is_running     = flags_ff.running;
   assign rsp_alarm_on       = flags_ff.alarm;

endmodule
`default_nettype wire

// ----- tb/tb_stopwatch_countdown_timer_unit.sv -----
// Self-checking testbench for the stopwatch / countdown timer unit.
`default_nettype none
module tb_stopwatch_countdown_timer_unit;
   import sctu_pkg::*;

   localparam int          CLK_PERIOD       = 20;
   localparam int unsigned TIME_W           = 14;
   localparam int          PHASES           = 6;
   localparam int          RANDOM_PER_PHASE = 72;
   localparam int          REPORT_LIMIT     = 10;
   localparam int          DIRECTED_ROWS    = 26;

   // Index 3 is not mapped; a write there must leave every register alone.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   // One request: tick flag then the five button levels. The bit order
   // matches the 6-bit row literals below: {tick, start, mode, clear, up, down}.
   typedef struct packed {
      logic    tick;
      btn_type btn;
   } sample_type;

   // One response, in port order.
   typedef struct packed {
      logic [SECONDS_W-1:0] seconds;
      logic                 countdown;
      logic                 running;
      logic                 alarm;
   } reading_type;

   // Directed row: request, and a hand-written response where it is obvious.
   typedef struct packed {
      sample_type  item_in;
      logic        fixed;
      reading_type want;
   } row_type;

   // ------------------------------------------------------------------
   // Clock, reset and DUT pins. Every input starts at a known value.
   // ------------------------------------------------------------------
   logic clock;
   logic reset                   = 1'b1;
   logic req_valid               = 1'b0;
   logic req_tick                = 1'b0;
   logic req_start_stop_pressed  = 1'b0;
   logic req_mode_pressed        = 1'b0;
   logic req_clear_pressed       = 1'b0;
   logic req_up_pressed          = 1'b0;
   logic req_down_pressed        = 1'b0;
   logic rsp_stall               = 1'b0;
   logic csr_valid               = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic                 req_stall;
   logic                 rsp_valid;
   logic [SECONDS_W-1:0] rsp_seconds_value;
   logic                 rsp_countdown_mode;
   logic                 rsp_is_running;
   logic                 rsp_alarm_on;
   logic                 csr_ready;

   always begin
      clock = 1'b0;
      #(CLK_PERIOD / 2);
      clock = 1'b1;
      #(CLK_PERIOD / 2);
   end

   stopwatch_countdown_timer_unit #(
      .TIME_BITS (TIME_W)
   ) u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_tick               (req_tick),
      .req_start_stop_pressed (req_start_stop_pressed),
      .req_mode_pressed       (req_mode_pressed),
      .req_clear_pressed      (req_clear_pressed),
      .req_up_pressed         (req_up_pressed),
      .req_down_pressed       (req_down_pressed),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_seconds_value      (rsp_seconds_value),
      .rsp_countdown_mode     (rsp_countdown_mode),
      .rsp_is_running         (rsp_is_running),
      .rsp_alarm_on           (rsp_alarm_on),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Timer predictor: a private copy of the registers and the state.
   // ------------------------------------------------------------------
   cfg_type              timer_cfg;
   logic [TIME_W-1:0]    seconds_q;
   logic                 countdown_q;
   logic                 running_q;
   logic                 alarm_q;
   logic [TICK_W-1:0]    tick_count_q;
   btn_type              last_buttons;

   // Responses still owed by the DUT, oldest first.
   reading_type pending_readings[$];

   // Bookkeeping.
   int          fail_count       = 0;
   int          checked_count    = 0;
   int          sent_count       = 0;
   int          alarm_events     = 0;
   int          send_gap_pct     = 0;
   int          stall_pct        = 0;
   btn_type     held_buttons     = '0;

   // Advance the timer by one sample and return what the DUT should show.
   // Buttons act on the press edge only, mode first, then start/stop,
   // clear, and finally up/down (only when stopped in countdown mode).
   task automatic predict_reading(input sample_type s, output reading_type r);
      btn_type rise;
      rise = btn_type'(s.btn & ~last_buttons);
      if (rise.mode) begin
         countdown_q = ~countdown_q;
         running_q   = 1'b0;
      end
      if (rise.start_stop) begin
         running_q = ~running_q;
         if (running_q)
            alarm_q = 1'b0;
      end
      if (rise.clear) begin
         seconds_q = '0;
         alarm_q   = 1'b0;
      end
      if (countdown_q && !running_q) begin
         if (rise.up && seconds_q < timer_cfg.setting_limit && seconds_q != '1)
            seconds_q = seconds_q + 1'b1;
         if (rise.down && seconds_q != '0)
            seconds_q = seconds_q - 1'b1;
      end
      last_buttons = s.btn;

      // Ticks only count while running; a ticks-per-second of zero makes
      // every tick a full second since the compare is always true.
      if (s.tick && running_q) begin
         tick_count_q = tick_count_q + 1'b1;
         if (tick_count_q >= timer_cfg.ticks_per_second) begin
            tick_count_q = '0;
            if (!countdown_q) begin
               if (seconds_q < timer_cfg.count_up_limit && seconds_q != '1)
                  seconds_q = seconds_q + 1'b1;
            end else if (seconds_q != '0) begin
               seconds_q = seconds_q - 1'b1;
               if (seconds_q == '0) begin
                  alarm_q = 1'b1;
                  alarm_events++;
               end
            end
         end
      end
      r = '{seconds_q[SECONDS_W-1:0], countdown_q, running_q, alarm_q};
   endtask

   task automatic note_failure(input string what, input reading_type want,
                               input reading_type got);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("[%0t] %s: expected sec=%0d mode=%0b run=%0b alarm=%0b, got sec=%0d mode=%0b run=%0b alarm=%0b",
                  $realtime, what, want.seconds, want.countdown, want.running, want.alarm,
                  got.seconds, got.countdown, got.running, got.alarm);
   endtask

   // ------------------------------------------------------------------
   // Request side. Fields are driven at the clock edge with NBAs; the
   // request counts as accepted at the first edge where req_stall is low.
   // The prediction is made at acceptance, so stalls cannot skew it.
   // ------------------------------------------------------------------
   task automatic send_sample(input sample_type s, input logic use_fixed,
                              input reading_type fixed);
      reading_type predicted;
      req_valid              <= 1'b1;
      req_tick               <= s.tick;
      req_start_stop_pressed <= s.btn.start_stop;
      req_mode_pressed       <= s.btn.mode;
      req_clear_pressed      <= s.btn.clear;
      req_up_pressed         <= s.btn.up;
      req_down_pressed       <= s.btn.down;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_reading(s, predicted);
      pending_readings.push_back(use_fixed ? fixed : predicted);
      sent_count++;
   endtask

   // Random hold-off between requests, in bursts.
   task automatic maybe_gap();
      if ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10))
            @(posedge clock);
      end
   endtask

   // Button levels are mostly held from sample to sample and flip now and
   // then, so presses and releases form clean edges. Mode flips rarely so
   // countdowns get set up, started and run out. One sample in ten is noise.
   function automatic sample_type next_random_sample();
      sample_type s;
      if ($urandom_range(0, 9) == 0) begin
         s = sample_type'($urandom_range(0, 63));
      end else begin
         s.btn = held_buttons;
         if ($urandom_range(0, 11) == 0) s.btn.mode       = ~s.btn.mode;
         if ($urandom_range(0, 5) == 0)  s.btn.start_stop = ~s.btn.start_stop;
         if ($urandom_range(0, 15) == 0) s.btn.clear      = ~s.btn.clear;
         if ($urandom_range(0, 2) == 0)  s.btn.up         = ~s.btn.up;
         if ($urandom_range(0, 3) == 0)  s.btn.down       = ~s.btn.down;
         s.tick = ($urandom_range(0, 2) != 0);
      end
      held_buttons = s.btn;
      return s;
   endfunction

   // Register write; the caller drops csr_valid after its last write so
   // back-to-back writes never see two NBAs to it in one step.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_COUNT_UP_LIMIT:   timer_cfg.count_up_limit   = data[LIMIT_W-1:0];
         CSR_SETTING_LIMIT:    timer_cfg.setting_limit    = data[LIMIT_W-1:0];
         CSR_TICKS_PER_SECOND: timer_cfg.ticks_per_second = data[TICK_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_readings.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Response side: check every accepted response against the oldest
   // expectation, then pick the stall for the next cycle. Stall comes
   // in bursts at a rate set per phase.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : response_check
      reading_type got;
      reading_type want;
      int          stall_left;
      got = '{rsp_seconds_value, rsp_countdown_mode, rsp_is_running, rsp_alarm_on};
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            note_failure("response with nothing pending", '0, got);
         end else begin
            want = pending_readings.pop_front();
            checked_count++;
            if (got.seconds !== want.seconds || got.countdown !== want.countdown ||
                got.running !== want.running || got.alarm !== want.alarm)
               note_failure("response mismatch", want, got);
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!reset && $urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(1, 10) - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Directed rows, run at the reset register values (2 ticks a second).
   // Rows marked fixed carry a hand-written response; the rest use the
   // predictor. Row bits: {tick, start, mode, clear, up, down}.
   // ------------------------------------------------------------------
   row_type directed_rows [DIRECTED_ROWS] = '{
      '{6'b0_00000, 1'b1, '{14'd0, 1'b0, 1'b0, 1'b0}}, // idle right after reset
      '{6'b1_00000, 1'b1, '{14'd0, 1'b0, 1'b0, 1'b0}}, // tick while stopped
      '{6'b0_00010, 1'b1, '{14'd0, 1'b0, 1'b0, 1'b0}}, // up in stopwatch mode
      '{6'b0_01000, 1'b1, '{14'd0, 1'b1, 1'b0, 1'b0}}, // mode -> countdown
      '{6'b0_00001, 1'b1, '{14'd0, 1'b1, 1'b0, 1'b0}}, // down at zero
      '{6'b0_00010, 1'b0, '0},                         // up -> 1
      '{6'b0_00000, 1'b0, '0},
      '{6'b0_00010, 1'b0, '0},                         // up -> 2
      '{6'b0_00011, 1'b0, '0},                         // up held, down edge
      '{6'b0_00000, 1'b0, '0},
      '{6'b0_00011, 1'b0, '0},                         // up and down together
      '{6'b1_10000, 1'b0, '0},                         // start with a tick
      '{6'b1_10000, 1'b0, '0},                         // reaches zero: alarm
      '{6'b1_10010, 1'b0, '0},                         // up while running
      '{6'b1_10000, 1'b0, '0},                         // second at zero
      '{6'b0_00000, 1'b0, '0},
      '{6'b0_10000, 1'b0, '0},                         // stop keeps the alarm
      '{6'b0_00100, 1'b0, '0},                         // clear drops it
      '{6'b0_10000, 1'b0, '0},                         // countdown started at zero
      '{6'b1_00000, 1'b0, '0},
      '{6'b1_00000, 1'b0, '0},                         // stays zero, no alarm
      '{6'b1_11111, 1'b1, '{14'd0, 1'b0, 1'b1, 1'b0}}, // every button at once
      '{6'b1_11111, 1'b0, '0},                         // all held: first second
      '{6'b1_00000, 1'b0, '0},
      '{6'b1_00000, 1'b0, '0},
      '{6'b0_01000, 1'b0, '0}                          // mode while running stops
   };

   // ------------------------------------------------------------------
   // Main sequence: reset, directed rows, then six phases of random
   // samples, each under its own register setting and idle rates. The
   // last phase runs with no idling on either side.
   // ------------------------------------------------------------------
   initial begin : stimulus
      timer_cfg    = '{RST_COUNT_UP_LIMIT, RST_SETTING_LIMIT, RST_TICKS_PER_SECOND};
      seconds_q    = '0;
      countdown_q  = 1'b0;
      running_q    = 1'b0;
      alarm_q      = 1'b0;
      tick_count_q = '0;
      last_buttons = '0;

      repeat (4)
         @(posedge clock);
      reset <= 1'b0;

      send_gap_pct = 20;
      stall_pct    = 20;
      foreach (directed_rows[i]) begin
         maybe_gap();
         send_sample(directed_rows[i].item_in, directed_rows[i].fixed,
                     directed_rows[i].want);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         // Registers only change once every response is back.
         if (phase != 0) begin
            req_valid <= 1'b0;
            wait_drained();
            case (phase)
               1: begin // tiny limits, every tick a second
                  write_register(CSR_COUNT_UP_LIMIT, 14'd3);
                  write_register(CSR_SETTING_LIMIT, 14'd2);
                  write_register(CSR_TICKS_PER_SECOND, 14'd1);
                  send_gap_pct = 30;
                  stall_pct    = 10;
               end
               2: begin // lowest limits, most ticks per second
                  write_register(CSR_COUNT_UP_LIMIT, 14'd1);
                  write_register(CSR_SETTING_LIMIT, 14'd1);
                  write_register(CSR_TICKS_PER_SECOND, 14'd15);
                  send_gap_pct = 0;
                  stall_pct    = 25;
               end
               3: begin // full-scale limits, zero ticks per second
                  write_register(CSR_COUNT_UP_LIMIT, 14'h3FFF);
                  write_register(CSR_SETTING_LIMIT, 14'h3FFF);
                  write_register(CSR_TICKS_PER_SECOND, 14'd0);
                  send_gap_pct = 15;
                  stall_pct    = 0;
               end
               4: begin // random small setting; junk in the unused bits
                  write_register(CSR_COUNT_UP_LIMIT, 14'($urandom_range(1, 40)));
                  write_register(CSR_SETTING_LIMIT, 14'($urandom_range(1, 40)));
                  write_register(CSR_TICKS_PER_SECOND,
                                 {10'($urandom), 4'($urandom_range(1, 4))});
                  write_register(CSR_UNMAPPED, 14'($urandom));
                  send_gap_pct = 25;
                  stall_pct    = 25;
               end
               default: begin // back to the reset values, no idling
                  write_register(CSR_COUNT_UP_LIMIT, RST_COUNT_UP_LIMIT);
                  write_register(CSR_SETTING_LIMIT, RST_SETTING_LIMIT);
                  write_register(CSR_TICKS_PER_SECOND, 14'(RST_TICKS_PER_SECOND));
                  send_gap_pct = 0;
                  stall_pct    = 0;
               end
            endcase
            csr_valid <= 1'b0;
         end
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            maybe_gap();
            send_sample(next_random_sample(), 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      // Drain, then let the clock run on so that any stray response can
      // show.
      wait_drained();
      repeat (8)
         @(posedge clock);

      $display("Sent %0d requests (%0d directed) over %0d register settings.",
               sent_count, DIRECTED_ROWS, PHASES);
      $display("Checked %0d responses, %0d countdown alarms, %0d failures.",
               checked_count, alarm_events, fail_count);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Hard stop: far beyond the slowest legal run (about 500 requests,
   // each with the longest gap and the longest response stall).
   initial begin : watchdog
      #(CLK_PERIOD * 300_000);
      $display("Timeout with %0d responses outstanding.", pending_readings.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
`default_nettype wire
